### rtl/core/ssr_pkg.sv
package ssr_pkg;

    localparam int MAX_SYSTS   = 32;
    localparam int MAX_BINS    = 32;
    localparam int SEGMENTS    = 6;
    localparam int COMPONENTS  = 3;
    localparam int STORE_DEPTH = COMPONENTS * MAX_SYSTS * SEGMENTS * MAX_BINS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COEF_W      = 32;
    localparam int PROD_W      = 66;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SHIFT = 2'd1;
    localparam logic [1:0] OP_APPLY = 2'd2;

    localparam logic [0:0] REG_ACTIVE_SYSTS = 1'd0;
    localparam logic [0:0] REG_LOWEST_SHIFT = 1'd1;

    localparam logic signed [15:0] LOWEST_SHIFT_RST = -16'sd12288;
    localparam logic signed [31:0] ONE_Q20          = 32'sh0010_0000;
    localparam logic [2:0]         LAST_SEG         = 3'(SEGMENTS - 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_ADDR  = 10'b00_0000_0010,
        ST_READ  = 10'b00_0000_0100,
        ST_LATCH = 10'b00_0000_1000,
        ST_MUL   = 10'b00_0001_0000,
        ST_ACC   = 10'b00_0010_0000,
        ST_CMUL  = 10'b00_0100_0000,
        ST_CACC  = 10'b00_1000_0000,
        ST_FMUL  = 10'b01_0000_0000,
        ST_FACC  = 10'b10_0000_0000
    } state_t;

    // ((comp * MAX_SYSTS + syst) * SEGMENTS + seg) * MAX_BINS + bin
    function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0] comp,
                                                     input logic [4:0] syst,
                                                     input logic [2:0] seg,
                                                     input logic [4:0] bin);
        logic [9:0] row;
        row = 10'({comp, syst}) * 10'(SEGMENTS) + 10'(seg);
        return ADDR_W'({row, bin});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        if (x > PROD_W'(signed'(32'sh7FFF_FFFF)))
            return 32'sh7FFF_FFFF;
        else if (x < PROD_W'(signed'(32'sh8000_0000)))
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

endpackage

### rtl/core/ssr_ram.sv
module ssr_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 18432
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/spline_syst_reweight.sv
// channel  dir  handshake              payload
// s        in   s_tvalid / s_tready    s_tdata (item fields), s_tuser (opcode)
// m        out  m_tvalid / m_tready    m_tdata (bin, value), m_tuser (saturated)
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Load and shift items complete on acceptance; s_tready stays high. An apply
// item covers min(active_systs, 32) systematics, each with a shift lookup, a
// coefficient read and four passes through the one shared 33x33 multiplier.
// Reset clears the shift store and control state; the coefficient store is not
// cleared. An unclaimed result holds the finishing apply item until m_tready.
module spline_syst_reweight (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // component, syst_index, segment, bin_index, coef_a, coef_b, coef_c,
    // coef_d, shift_value, bin_value, zero pad
    input  logic [191:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_bin_index, scaled_value, zero pad
    output logic [39:0]  m_tdata,
    // saturated
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import ssr_pkg::*;

    logic [1:0]  in_comp;
    logic [4:0]  in_syst;
    logic [2:0]  in_seg;
    logic [4:0]  in_bin;
    logic [4*COEF_W-1:0] in_coefs;
    logic signed [15:0] in_shift;
    logic [31:0] in_value;

    assign in_comp  = s_tdata[1:0];
    assign in_syst  = s_tdata[6:2];
    assign in_seg   = s_tdata[9:7];
    assign in_bin   = s_tdata[14:10];
    assign in_coefs = s_tdata[142:15];
    assign in_shift = s_tdata[158:143];
    assign in_value = s_tdata[190:159];

    state_t state_reg, state_next;

    logic [5:0]  active_reg;
    logic signed [15:0] lowest_reg;
    logic signed [15:0] shift_reg [MAX_SYSTS];

    logic [5:0]  n_reg;
    logic [5:0]  syst_cnt_reg;
    logic [1:0]  horn_cnt_reg;
    logic [1:0]  comp_reg;
    logic [4:0]  bin_reg;
    logic [31:0] value_reg;
    logic signed [16:0] t_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic signed [31:0] coef_reg [3];
    logic signed [31:0] p_reg;
    logic signed [31:0] corr_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic        out_valid_reg;
    logic [4:0]  out_bin_reg;
    logic [31:0] out_value_reg;
    logic        out_sat_reg;

    logic accept;
    logic [4*COEF_W-1:0] rd_data;
    logic load_wr;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign load_wr   = accept && (s_tuser == OP_LOAD) && (in_comp < 2'(COMPONENTS))
                       && (in_seg < 3'(SEGMENTS));

    ssr_ram #(
        .WIDTH (4 * COEF_W),
        .DEPTH (STORE_DEPTH)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (store_addr(in_comp, in_syst, in_seg, in_bin)),
        .wr_data (in_coefs),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // segment selection
    logic signed [16:0] diff;
    logic [2:0]         sg;
    logic signed [16:0] t_val;

    always_comb
    begin
        diff = 17'(shift_reg[syst_cnt_reg[4:0]]) - 17'(lowest_reg);
        if (diff[16])
            sg = 3'd0;
        else if (diff[15:12] > 4'(LAST_SEG))
            sg = LAST_SEG;
        else
            sg = diff[14:12];
        t_val = diff - signed'({2'b00, sg, 12'd0});
    end

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_out;
    logic [31:0] corr_pos;

    assign corr_pos = corr_reg[31] ? 32'd0 : corr_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_CMUL:
            begin
                mul_a = 33'(corr_reg);
                mul_b = 33'(p_reg);
            end
            ST_FMUL:
            begin
                mul_a = signed'({1'b0, value_reg});
                mul_b = signed'({1'b0, corr_pos});
            end
            default:
            begin
                mul_a = 33'(p_reg);
                mul_b = 33'(t_reg);
            end
        endcase
        mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    logic signed [PROD_W-1:0] horn_sum;
    logic signed [PROD_W-1:0] fin;
    logic                     fin_sat;

    always_comb
    begin
        horn_sum = ((prod_reg + PROD_W'(2048)) >>> 12) + PROD_W'(coef_reg[horn_cnt_reg]);
        fin      = (prod_reg + PROD_W'(524288)) >>> 20;
        fin_sat  = fin > PROD_W'(33'sh0_FFFF_FFFF);
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == OP_APPLY) && (in_comp < 2'(COMPONENTS)))
                    state_next = (active_reg == 6'd0) ? ST_FMUL : ST_ADDR;
            end
            ST_ADDR:  state_next = ST_READ;
            ST_READ:  state_next = ST_LATCH;
            ST_LATCH: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = (horn_cnt_reg == 2'd2) ? ST_CMUL : ST_MUL;
            ST_CMUL:  state_next = ST_CACC;
            ST_CACC:  state_next = (syst_cnt_reg + 6'd1 == n_reg) ? ST_FMUL : ST_ADDR;
            ST_FMUL:  state_next = ST_FACC;
            ST_FACC:  state_next = out_free ? ST_IDLE : ST_FACC;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 6'd0;
            lowest_reg    <= LOWEST_SHIFT_RST;
            out_valid_reg <= 1'b0;
            syst_cnt_reg  <= 6'd0;
            horn_cnt_reg  <= 2'd0;
            for (int i = 0; i < MAX_SYSTS; i++)
            begin
                shift_reg[i] <= 16'sd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ACTIVE_SYSTS: active_reg <= cfg_data[5:0];
                    REG_LOWEST_SHIFT: lowest_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && (s_tuser == OP_SHIFT))
            begin
                shift_reg[in_syst] <= in_shift;
            end
            // a new result replaces the one taken in the same cycle
            if ((state_reg == ST_FACC) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    syst_cnt_reg <= 6'd0;
                    horn_cnt_reg <= 2'd0;
                end
                ST_ACC:
                begin
                    horn_cnt_reg <= (horn_cnt_reg == 2'd2) ? 2'd0 : horn_cnt_reg + 2'd1;
                end
                ST_CACC:
                begin
                    syst_cnt_reg <= syst_cnt_reg + 6'd1;
                end
                default: ;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                comp_reg  <= in_comp;
                bin_reg   <= in_bin;
                value_reg <= in_value;
                corr_reg  <= ONE_Q20;
                n_reg     <= (active_reg > 6'(MAX_SYSTS)) ? 6'(MAX_SYSTS) : active_reg;
            end
            ST_ADDR:
            begin
                t_reg    <= t_val;
                addr_reg <= store_addr(comp_reg, syst_cnt_reg[4:0], sg, bin_reg);
            end
            ST_LATCH:
            begin
                p_reg       <= rd_data[31:0];
                coef_reg[0] <= rd_data[63:32];
                coef_reg[1] <= rd_data[95:64];
                coef_reg[2] <= rd_data[127:96];
            end
            ST_MUL, ST_CMUL, ST_FMUL:
            begin
                prod_reg <= mul_out;
            end
            ST_ACC:
            begin
                p_reg <= sat32(horn_sum);
            end
            ST_CACC:
            begin
                corr_reg <= sat32((prod_reg + PROD_W'(524288)) >>> 20);
            end
            ST_FACC:
            begin
                if (out_free)
                begin
                    out_bin_reg   <= bin_reg;
                    out_value_reg <= fin_sat ? 32'hFFFF_FFFF : fin[31:0];
                    out_sat_reg   <= fin_sat;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {3'd0, out_value_reg, out_bin_reg};
    assign m_tuser[0] = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_syst_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (syst_cnt_reg <= n_reg))
        else $error("systematic counter beyond count");

    a_horn_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        horn_cnt_reg != 2'd3)
        else $error("Horner step counter out of range");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_APPLY) && (in_comp < 2'(COMPONENTS))) |=> !s_tready)
        else $error("ready while apply item in progress");

    a_final_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FACC) |-> !prod_reg[PROD_W-1])
        else $error("negative final product");
`endif

endmodule
